// ===== hdl/matrix4x4_multiply_engine_top_macros.svh =====
// assertion macros shared by the matrix multiply engine rtl
`ifndef MATRIX4X4_MULTIPLY_ENGINE_TOP_MACROS_SVH
`define MATRIX4X4_MULTIPLY_ENGINE_TOP_MACROS_SVH

// same-cycle implication, checked out of reset
`define M4ME_ASSERT_NOW(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |-> (expr)) \
        else $error("same-cycle check failed");

// next-cycle implication, checked out of reset
`define M4ME_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond) |=> (expr)) \
        else $error("next-cycle check failed");

`endif

// ===== hdl/m4me_pkg.sv =====
// package: request types, operation codes and defaults of the matrix multiply engine
package m4me_pkg;

    // default matrix dimension
    localparam int DIM_DEFAULT = 4;

    // fixed field widths
    localparam int IDX_FIELD_W = 2;
    localparam int VALUE_W     = 32;
    localparam int PROD_W      = 2 * VALUE_W;
    localparam int FRAC_W      = 16;

    // operation codes
    localparam logic [1:0] OP_LOAD_FIRST  = 2'd0;
    localparam logic [1:0] OP_LOAD_SECOND = 2'd1;
    localparam logic [1:0] OP_MULTIPLY    = 2'd2;

    // saturation limits
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;

    // input request
    typedef struct packed {
        logic [1:0]                operation;
        logic [IDX_FIELD_W-1:0]    row_index;
        logic [IDX_FIELD_W-1:0]    column_index;
        logic signed [VALUE_W-1:0] element_value;
    } t_in_req;

    // output request
    typedef struct packed {
        logic [IDX_FIELD_W-1:0]    result_row;
        logic [IDX_FIELD_W-1:0]    result_column;
        logic signed [VALUE_W-1:0] result_value;
        logic                      saturated;
        logic                      last_result;
    } t_out_req;

    // element write broadcast to every cell
    typedef struct packed {
        logic                      we_first;
        logic                      we_second;
        logic [IDX_FIELD_W-1:0]    row_index;
        logic [IDX_FIELD_W-1:0]    column_index;
        logic signed [VALUE_W-1:0] value;
    } t_load_req;

    // control that travels with each partial sum
    typedef struct packed {
        logic valid;
        logic last;
    } t_tag;

endpackage

// ===== hdl/m4me_mac_cell.sv =====
// one multiply-accumulate cell: holds column k of the first matrix and row k of the second
module m4me_mac_cell #(
    parameter int MATRIX_DIM = 4,
    parameter int CELL_IDX   = 0,
    parameter int IDX_W      = 2,
    parameter int SUM_W      = 66
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  m4me_pkg::t_load_req      i_load,
    input  m4me_pkg::t_tag           i_tag,
    input  logic [IDX_W-1:0]         i_row,
    input  logic [IDX_W-1:0]         i_col,
    input  logic signed [SUM_W-1:0]  i_sum,
    output m4me_pkg::t_tag           o_tag,
    output logic [IDX_W-1:0]         o_row,
    output logic [IDX_W-1:0]         o_col,
    output logic signed [SUM_W-1:0]  o_sum
);
    import m4me_pkg::*;

    logic signed [VALUE_W-1:0] r_first_col  [MATRIX_DIM];
    logic signed [VALUE_W-1:0] r_second_row [MATRIX_DIM];

    t_tag                     r_tag_a, r_tag_b;
    logic [IDX_W-1:0]         r_row_a, r_col_a, r_row_b, r_col_b;
    logic signed [SUM_W-1:0]  r_sum_a, r_sum_b;
    logic signed [PROD_W-1:0] r_prod;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [SUM_W-1:0]  n_sum;
    logic                     hit_first, hit_second;

    // element stores, cleared at reset
    assign hit_first  = i_load.we_first  && (32'(i_load.column_index) == CELL_IDX);
    assign hit_second = i_load.we_second && (32'(i_load.row_index) == CELL_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int e = 0; e < MATRIX_DIM; e++) begin
                r_first_col[e]  <= '0;
                r_second_row[e] <= '0;
            end
        end else begin
            if (hit_first) begin
                r_first_col[IDX_W'(i_load.row_index)] <= i_load.value;
            end
            if (hit_second) begin
                r_second_row[IDX_W'(i_load.column_index)] <= i_load.value;
            end
        end
    end

    // product of a[i][k] and b[k][j]
    assign n_prod = PROD_W'(r_first_col[i_row]) * PROD_W'(r_second_row[i_col]);

    // accumulate onto the incoming partial sum
    assign n_sum = r_sum_a + SUM_W'(r_prod);

    // control of the two stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag_a <= '0;
            r_tag_b <= '0;
        end else if (i_en) begin
            r_tag_a <= i_tag;
            r_tag_b <= r_tag_a;
        end
    end

    // data of the two stages
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row_a <= i_row;
            r_col_a <= i_col;
            r_sum_a <= i_sum;
            r_prod  <= n_prod;
            r_row_b <= r_row_a;
            r_col_b <= r_col_a;
            r_sum_b <= n_sum;
        end
    end

    assign o_tag = r_tag_b;
    assign o_row = r_row_b;
    assign o_col = r_col_b;
    assign o_sum = r_sum_b;

endmodule

// ===== hdl/matrix4x4_multiply_engine_top.sv =====
// top level of the matrix multiply engine: request decode, element issue, cell chain, output stage
// Multiplies two MATRIX_DIM x MATRIX_DIM matrices in signed Q16.16. A load request (first or
// second matrix) is taken and writes one element; loads outside the matrix and
// the unused operation code are dropped. A multiply request streams all MATRIX_DIM*MATRIX_DIM
// product elements in row-major order, one per cycle when the consumer keeps ready high; the
// engine takes no new request from the multiply until its last element has been taken.
// Elements are issued one per cycle while the output does not stall, into a chain of
// MATRIX_DIM multiply-accumulate cells, each two registered stages deep, followed by
// the shift and saturation output register. Sums are exact, shifted right by 16 (floor)
// and clamped to 32 bits with the saturated flag set. Both stores read as zero after reset.
`include "matrix4x4_multiply_engine_top_macros.svh"

module matrix4x4_multiply_engine_top #(
    parameter int MATRIX_DIM = m4me_pkg::DIM_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  m4me_pkg::t_in_req  i_in_req,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output m4me_pkg::t_out_req o_out_req
);
    import m4me_pkg::*;

    localparam int IDX_W = $clog2(MATRIX_DIM);
    localparam int SUM_W = PROD_W + $clog2(MATRIX_DIM);

    logic                    in_fire, in_range, start_mult, en, issue_last, out_fire;
    t_load_req               load;
    logic                    r_busy, r_issuing;
    logic [IDX_W-1:0]        r_i, r_j;
    logic [IDX_W-1:0]        n_i, n_j;
    logic                    r_out_valid;
    t_out_req                r_out_req, n_out_req;
    logic [SUM_W-48:0]       sum_upper;

    t_tag                    chain_tag [MATRIX_DIM+1];
    logic [IDX_W-1:0]        chain_row [MATRIX_DIM+1];
    logic [IDX_W-1:0]        chain_col [MATRIX_DIM+1];
    logic signed [SUM_W-1:0] chain_sum [MATRIX_DIM+1];

    // request decode
    assign o_in_ready = !r_busy;
    assign in_fire    = i_in_valid && o_in_ready;
    assign in_range   = (32'(i_in_req.row_index) < MATRIX_DIM) &&
                        (32'(i_in_req.column_index) < MATRIX_DIM);

    always_comb begin
        load.we_first     = 1'b0;
        load.we_second    = 1'b0;
        load.row_index    = i_in_req.row_index;
        load.column_index = i_in_req.column_index;
        load.value        = i_in_req.element_value;
        start_mult        = 1'b0;
        unique case (i_in_req.operation)
            OP_LOAD_FIRST:  load.we_first  = in_fire && in_range;
            OP_LOAD_SECOND: load.we_second = in_fire && in_range;
            OP_MULTIPLY:    start_mult     = in_fire;
            default:        start_mult     = 1'b0;
        endcase
    end

    // the whole chain moves when the output register can take a new element
    assign en       = !r_out_valid || i_out_ready;
    assign out_fire = r_out_valid && i_out_ready;

    // element issue, row-major
    assign issue_last = (r_i == IDX_W'(MATRIX_DIM - 1)) && (r_j == IDX_W'(MATRIX_DIM - 1));

    always_comb begin
        n_i = r_i;
        n_j = r_j;
        if (r_j == IDX_W'(MATRIX_DIM - 1)) begin
            n_j = '0;
            n_i = r_i + IDX_W'(1);
        end else begin
            n_j = r_j + IDX_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_issuing <= 1'b0;
            r_i       <= '0;
            r_j       <= '0;
        end else begin
            if (start_mult) begin
                r_busy    <= 1'b1;
                r_issuing <= 1'b1;
                r_i       <= '0;
                r_j       <= '0;
            end else begin
                if (out_fire && r_out_req.last_result) begin
                    r_busy <= 1'b0;
                end
                if (en && r_issuing) begin
                    r_i <= n_i;
                    r_j <= n_j;
                    if (issue_last) begin
                        r_issuing <= 1'b0;
                    end
                end
            end
        end
    end

    // head of the chain
    assign chain_tag[0] = '{valid: r_issuing, last: issue_last};
    assign chain_row[0] = r_i;
    assign chain_col[0] = r_j;
    assign chain_sum[0] = '0;

    // chain of multiply-accumulate cells
    for (genvar k = 0; k < MATRIX_DIM; k++) begin : g_cell
        m4me_mac_cell #(
            .MATRIX_DIM (MATRIX_DIM),
            .CELL_IDX   (k),
            .IDX_W      (IDX_W),
            .SUM_W      (SUM_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_load  (load),
            .i_tag   (chain_tag[k]),
            .i_row   (chain_row[k]),
            .i_col   (chain_col[k]),
            .i_sum   (chain_sum[k]),
            .o_tag   (chain_tag[k+1]),
            .o_row   (chain_row[k+1]),
            .o_col   (chain_col[k+1]),
            .o_sum   (chain_sum[k+1])
        );
    end

    // shift by the fraction width and clamp to 32 bits
    assign sum_upper = chain_sum[MATRIX_DIM][SUM_W-1:FRAC_W+VALUE_W-1];

    always_comb begin
        n_out_req.result_row    = IDX_FIELD_W'(chain_row[MATRIX_DIM]);
        n_out_req.result_column = IDX_FIELD_W'(chain_col[MATRIX_DIM]);
        n_out_req.last_result   = chain_tag[MATRIX_DIM].last;
        if ((&sum_upper) || !(|sum_upper)) begin
            n_out_req.saturated    = 1'b0;
            n_out_req.result_value = chain_sum[MATRIX_DIM][FRAC_W+VALUE_W-1:FRAC_W];
        end else begin
            n_out_req.saturated    = 1'b1;
            n_out_req.result_value = chain_sum[MATRIX_DIM][SUM_W-1] ? VALUE_MIN : VALUE_MAX;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_out_valid <= chain_tag[MATRIX_DIM].valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_out_req <= n_out_req;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out_req;

    // checks
    `M4ME_ASSERT_NOW(a_out_only_busy, i_clk, i_rst_n, r_out_valid, r_busy)
    `M4ME_ASSERT_NOW(a_issue_only_busy, i_clk, i_rst_n, r_issuing, r_busy)
    `M4ME_ASSERT_NEXT(a_issue_stops, i_clk, i_rst_n, en && r_issuing && issue_last, !r_issuing)
    `M4ME_ASSERT_NEXT(a_ready_after_last, i_clk, i_rst_n,
        out_fire && r_out_req.last_result, o_in_ready)

endmodule

// ===== test/matrix4x4_multiply_engine_top_tb.sv =====
// self-checking testbench for the matrix multiply engine: q16.16 product prediction and checks
module matrix4x4_multiply_engine_top_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import m4me_pkg::*;

    localparam int DIM = DIM_DEFAULT;
    localparam int CELL_COUNT = DIM * DIM;
    localparam int CLK_HALF = 4;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_CYCLES = 40;
    localparam int PRINT_LIMIT = 40;

    // operation code that the engine drops
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // one q16.16 unit and minus one
    localparam logic signed [VALUE_W-1:0] FIX_ONE = 32'sh0001_0000;
    localparam logic signed [VALUE_W-1:0] FIX_MINUS_ONE = -32'sh0001_0000;

    // exact sums are kept in 68 bits, wide enough for four full products
    localparam logic signed [67:0] SUM_MAX = 68'sh0_7FFF_FFFF;
    localparam logic signed [67:0] SUM_MIN = -68'sh0_8000_0000;

    logic     i_clk;
    logic     i_rst_n;
    logic     i_in_valid;
    logic     o_in_ready;
    t_in_req  i_in_req;
    logic     o_out_valid;
    logic     i_out_ready;
    t_out_req o_out_req;

    int send_idle_pct;
    int stall_pct;
    int cycle_count;
    int request_count;

    // keeps both stores and the queue of expected product elements
    class product_scoreboard;
        logic signed [VALUE_W-1:0] first_store[CELL_COUNT];
        logic signed [VALUE_W-1:0] second_store[CELL_COUNT];
        t_out_req expected_q[$];
        int error_count;
        int element_count;
        int multiply_count;
        int clamp_count;

        function new();
            foreach (first_store[n]) begin
                first_store[n] = '0;
                second_store[n] = '0;
            end
            error_count = 0;
            element_count = 0;
            multiply_count = 0;
            clamp_count = 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // exact dot product of one row and one column, floored and clamped
        function t_out_req product_element(int row, int col);
            logic signed [67:0] acc;
            logic signed [67:0] lhs;
            logic signed [67:0] rhs;
            logic signed [67:0] shifted;
            t_out_req elem;
            acc = '0;
            for (int k = 0; k < DIM; k++) begin
                lhs = first_store[row * DIM + k];
                rhs = second_store[k * DIM + col];
                acc = acc + lhs * rhs;
            end
            shifted = acc >>> FRAC_W;
            elem.result_row = row[IDX_FIELD_W-1:0];
            elem.result_column = col[IDX_FIELD_W-1:0];
            elem.last_result = (row * DIM + col == CELL_COUNT - 1);
            if (shifted > SUM_MAX) begin
                elem.result_value = VALUE_MAX;
                elem.saturated = 1'b1;
            end else if (shifted < SUM_MIN) begin
                elem.result_value = VALUE_MIN;
                elem.saturated = 1'b1;
            end else begin
                elem.result_value = shifted[VALUE_W-1:0];
                elem.saturated = 1'b0;
            end
            return elem;
        endfunction

        // update the stores or queue the whole product for an accepted request
        function void note_request(t_in_req req);
            int slot;
            slot = req.row_index * DIM + req.column_index;
            if (req.operation == OP_MULTIPLY) begin
                multiply_count++;
                for (int r = 0; r < DIM; r++)
                    for (int c = 0; c < DIM; c++)
                        expected_q.push_back(product_element(r, c));
            end else if (req.row_index < DIM && req.column_index < DIM) begin
                if (req.operation == OP_LOAD_FIRST)
                    first_store[slot] = req.element_value;
                else if (req.operation == OP_LOAD_SECOND)
                    second_store[slot] = req.element_value;
            end
        endfunction

        task report_mismatch(string msg);
            if (error_count < PRINT_LIMIT)
                $display("[%0t] mismatch: %s", $time, msg);
            error_count++;
        endtask

        // compare one emitted element with the oldest expectation
        task check_result(t_out_req got);
            t_out_req want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected element (%0d,%0d) value %h",
                    got.result_row, got.result_column, got.result_value));
            end else begin
                want = expected_q.pop_front();
                element_count++;
                if (want.saturated)
                    clamp_count++;
                if (got.result_row !== want.result_row)
                    report_mismatch($sformatf("result_row %0d, expected %0d",
                        got.result_row, want.result_row));
                if (got.result_column !== want.result_column)
                    report_mismatch($sformatf("result_column %0d, expected %0d",
                        got.result_column, want.result_column));
                if (got.result_value !== want.result_value)
                    report_mismatch($sformatf("(%0d,%0d) result_value %h, expected %h",
                        want.result_row, want.result_column,
                        got.result_value, want.result_value));
                if (got.saturated !== want.saturated)
                    report_mismatch($sformatf("(%0d,%0d) saturated %b, expected %b",
                        want.result_row, want.result_column,
                        got.saturated, want.saturated));
                if (got.last_result !== want.last_result)
                    report_mismatch($sformatf("(%0d,%0d) last_result %b, expected %b",
                        want.result_row, want.result_column,
                        got.last_result, want.last_result));
            end
        endtask
    endclass

    product_scoreboard sb;

    matrix4x4_multiply_engine_top #(
        .MATRIX_DIM (DIM)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_req    (i_in_req),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_req   (o_out_req)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #(CLK_HALF) i_clk = ~i_clk;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        i_out_ready <= ($urandom_range(99) >= stall_pct);
    end

    // output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_result(o_out_req);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("matrix4x4_multiply_engine_top regression: fail");
            $finish;
        end
    end

    function automatic t_in_req make_req(logic [1:0] op, int row, int col,
                                         logic signed [VALUE_W-1:0] value);
        t_in_req req;
        req.operation = op;
        req.row_index = row[IDX_FIELD_W-1:0];
        req.column_index = col[IDX_FIELD_W-1:0];
        req.element_value = value;
        return req;
    endfunction

    // element values: extremes, full range, small, medium and unit values
    function automatic logic signed [VALUE_W-1:0] random_element();
        logic signed [VALUE_W-1:0] value;
        case ($urandom_range(9))
            0: value = VALUE_MAX;
            1: value = VALUE_MIN;
            2, 3: value = $urandom;
            4, 5, 6: value = $signed(32'($urandom_range(32'h0020_0000))) - 32'sh0010_0000;
            7, 8: value = $signed($urandom) >>> $urandom_range(4, 12);
            default: value = $urandom_range(1) ? FIX_ONE : FIX_MINUS_ONE;
        endcase
        return value;
    endfunction

    function automatic t_in_req random_load();
        return make_req($urandom_range(1) ? OP_LOAD_SECOND : OP_LOAD_FIRST,
                        $urandom_range(3), $urandom_range(3), random_element());
    endfunction

    function automatic t_in_req random_op(logic [1:0] op);
        return make_req(op, $urandom_range(3), $urandom_range(3), $urandom);
    endfunction

    // present one request from a falling edge and hold it until taken
    task automatic send_request(t_in_req req);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_req <= req;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_request(req);
        request_count++;
        @(negedge i_clk);
    endtask

    // hold the sender off until every expected element has come out
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending() != 0);
    endtask

    // corner cases: zero stores, clamping both ways, floor of negatives, ignored fields
    task automatic run_directed();
        send_request(make_req(OP_MULTIPLY, 0, 0, '0));
        for (int k = 0; k < DIM; k++)
            send_request(make_req(OP_LOAD_FIRST, 0, k, VALUE_MIN));
        for (int k = 0; k < DIM; k++)
            send_request(make_req(OP_LOAD_SECOND, k, 0, VALUE_MIN));
        send_request(make_req(OP_LOAD_SECOND, 0, 1, VALUE_MAX));
        send_request(make_req(OP_LOAD_FIRST, 3, 3, VALUE_MAX));
        send_request(make_req(OP_LOAD_SECOND, 3, 3, VALUE_MAX));
        send_request(make_req(OP_LOAD_SECOND, 3, 2, 32'sd1));
        send_request(make_req(OP_UNUSED, 3, 3, -32'sd1));
        send_request(make_req(OP_MULTIPLY, 3, 3, -32'sd1));
        send_request(make_req(OP_LOAD_FIRST, 1, 1, -32'sd1));
        send_request(make_req(OP_LOAD_SECOND, 1, 1, 32'sd1));
        send_request(make_req(OP_LOAD_FIRST, 3, 0, FIX_ONE));
        send_request(make_req(OP_LOAD_SECOND, 0, 3, FIX_MINUS_ONE));
        send_request(make_req(OP_UNUSED, 0, 0, '0));
        send_request(make_req(OP_MULTIPLY, 2, 1, VALUE_MAX));
    endtask

    // mostly load bursts closed by a multiply, with some stray requests mixed in
    task automatic run_phase(int idle_pct, int stall, int budget);
        int sent;
        int burst;
        send_idle_pct = idle_pct;
        stall_pct = stall;
        sent = 0;
        while (sent < budget) begin
            if ($urandom_range(9) < 8) begin
                burst = $urandom_range(1, 12);
                repeat (burst) send_request(random_load());
                send_request(random_op(OP_MULTIPLY));
                sent += burst + 1;
            end else begin
                case ($urandom_range(2))
                    0: send_request(random_op(OP_UNUSED));
                    1: begin
                        send_request(random_op(OP_MULTIPLY));
                        sent++;
                    end
                    default: begin
                        send_request(random_load());
                        sent++;
                    end
                endcase
            end
        end
        drain_results();
    endtask

    // stimulus and verdict
    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_req = '0;
        i_out_ready = 1'b0;
        send_idle_pct = 0;
        stall_pct = 0;
        cycle_count = 0;
        request_count = 0;

        // synchronous reset, released on a falling edge
        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        run_directed();
        drain_results();

        run_phase(0, 0, 90);
        run_phase(49, 0, 85);
        run_phase(0, 49, 85);
        run_phase(31, 31, 85);

        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("covered %0d requests and %0d multiplies: %0d product elements, %0d clamped",
                 request_count, sb.multiply_count, sb.element_count, sb.clamp_count);
        $display("idling phases: none, sender, receiver, both; %0d mismatches",
                 sb.error_count);
        if (sb.error_count == 0)
            $display("matrix4x4_multiply_engine_top regression: pass");
        else
            $display("matrix4x4_multiply_engine_top regression: fail");
        $finish;
    end

endmodule
